[sv/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
// No dependencies; compiled first.
`default_nettype none

package spq_pkg;

  // Field widths fixed by the item format
  localparam int IdWidth     = 16;
  localparam int PrioWidth   = 8;
  localparam int FillWidth   = 5;
  localparam int DefaultDepth = 16;

  // Request kinds
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic [IdWidth-1:0]   id;
    logic [PrioWidth-1:0] prio;
  } cmd_t;

endpackage

`default_nettype wire

[sv/spq_req_if.sv]
// Request channel: valid/ready handshake with insert/remove payload.
// Depends on nothing but fixed field widths.
`default_nettype none

interface spq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] item_id;
  logic [7:0]  priority_req;

  modport source (output valid, req_type, item_id, priority_req, input ready);
  modport sink   (input valid, req_type, item_id, priority_req, output ready);
endinterface

`default_nettype wire

[sv/spq_res_if.sv]
// Result channel: valid/ready handshake with status, served id and fill count.
// Depends on nothing but fixed field widths.
`default_nettype none

interface spq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] served_id;
  logic [4:0]  fill_count;

  modport source (output valid, status, served_id, fill_count, input ready);
  modport sink   (input valid, status, served_id, fill_count, output ready);
endinterface

`default_nettype wire

[sv/sorted_priority_queue.sv]
// Bounded priority queue built as a chain of shifting cells.
// Depends on spq_pkg, spq_req_if, spq_res_if and spq_cell.
//
// Usage:
//   req (sink): req_type 0 inserts {item_id, priority_req}, 1 removes the head.
//   res (source): one result item per request: status, served_id, fill_count.
//   Entries are kept highest priority first; equal priorities leave in
//   arrival order. Insert on a full queue returns status full and stores
//   nothing; remove on an empty queue returns status empty.
// Timing:
//   Every cell compares against the new priority and moves in the same
//   cycle, so a request is finished in the cycle it is accepted. Its result
//   appears in the output register on the next cycle, and one
//   request per cycle is taken while results are drained.
//   The depth of the compare is one cell; the fill count update sets the path.
// Reset (rst, synchronous): queue empty, no result pending. Slot contents are
//   not cleared; only slots below the fill count are ever read.
// Stall: while a result waits with res.ready low, req.ready is low; the
//   result holds until taken.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  spq_req_if.sink   req,
  spq_res_if.source res
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  cmd_t                 cmd;
  status_t              status_next;
  logic [IdWidth-1:0]   id_next;
  logic [CW+FillWidth-1:0] fill_wide;

  logic [IdWidth-1:0]   cell_id   [DEPTH];
  logic [PrioWidth-1:0] cell_prio [DEPTH];
  logic                 cell_lt   [DEPTH];

  // Handshake: take a request whenever the output register is free or draining
  assign req.ready = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;

  assign is_full  = count == CW'(DEPTH);
  assign is_empty = count == '0;

  // Command broadcast to the chain
  always_comb begin
    cmd.ins  = accept && (req_kind_t'(req.req_type) == REQ_INSERT) && !is_full;
    cmd.rem  = accept && (req_kind_t'(req.req_type) == REQ_REMOVE) && !is_empty;
    cmd.id   = req.item_id;
    cmd.prio = req.priority_req;
  end

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [IdWidth-1:0]   l_id;
    logic [PrioWidth-1:0] l_prio;
    logic                 l_lt;
    logic [IdWidth-1:0]   r_id;
    logic [PrioWidth-1:0] r_prio;

    if (i == 0) begin : g_head
      assign l_id   = '0;
      assign l_prio = '0;
      assign l_lt   = 1'b0;
    end else begin : g_mid
      assign l_id   = cell_id[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_lt   = cell_lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_id   = cell_id[i];
      assign r_prio = cell_prio[i];
    end else begin : g_body
      assign r_id   = cell_id[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .left_lt    (l_lt),
      .right_id   (r_id),
      .right_prio (r_prio),
      .slot_id    (cell_id[i]),
      .slot_prio  (cell_prio[i]),
      .lt         (cell_lt[i])
    );
  end

  // Fill count and result of the current request
  always_comb begin
    count_next  = count;
    status_next = ST_INSERTED;
    id_next     = '0;
    if (req_kind_t'(req.req_type) == REQ_INSERT) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        status_next = ST_REMOVED;
        id_next     = cell_id[0];
        count_next  = count - CW'(1);
      end
    end
  end

  // Fill count field carries the low bits of the entry count
  assign fill_wide = {{FillWidth{1'b0}}, count_next};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      res.status     <= status_next;
      res.served_id  <= id_next;
      res.fill_count <= fill_wide[FillWidth-1:0];
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the queue");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_kind_t'(req.req_type) == REQ_REMOVE) && is_empty) |=>
      (res.status == ST_EMPTY && res.served_id == '0))
    else $error("remove on empty queue gave wrong result");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == ST_EMPTY) |-> res.fill_count == '0)
    else $error("empty status with nonzero fill count");
`endif

endmodule

`default_nettype wire

[sv/spq_cell.sv]
// One slot of the sorted chain: holds an id and a priority, shifts with neighbours.
// Depends on spq_pkg.
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire cmd_t                 cmd,
  input  wire logic [CW-1:0]        count,
  input  wire logic [IdWidth-1:0]   left_id,
  input  wire logic [PrioWidth-1:0] left_prio,
  input  wire logic                 left_lt,
  input  wire logic [IdWidth-1:0]   right_id,
  input  wire logic [PrioWidth-1:0] right_prio,
  output logic      [IdWidth-1:0]   slot_id,
  output logic      [PrioWidth-1:0] slot_prio,
  output logic                      lt
);

  logic occupied;
  logic at_tail;

  // Slot is live below the fill count; the tail slot is the first free one
  assign occupied = CW'(IDX) < count;
  assign at_tail  = CW'(IDX) == count;

  // Strictly lower priority than the incoming entry: this slot moves back
  assign lt = occupied && (slot_prio < cmd.prio);

  // Insert: take from the left when it moves back, else open the gap here.
  // Remove: take from the right.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (left_lt) begin
        slot_id   <= left_id;
        slot_prio <= left_prio;
      end else if (lt || at_tail) begin
        slot_id   <= cmd.id;
        slot_prio <= cmd.prio;
      end
    end else if (cmd.rem) begin
      slot_id   <= right_id;
      slot_prio <= right_prio;
    end
  end

endmodule

`default_nettype wire

[bench/sorted_priority_queue_checker.sv]
// Checker for the sorted priority queue: watches both channels, keeps its own
// copy of the queue and compares every result item with the prediction.
// Depends on spq_pkg, spq_req_if and spq_res_if.
module sorted_priority_queue_checker import spq_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic clk,
  input  logic rst,
  spq_req_if   req,
  spq_res_if   res,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t              status;
    logic [IdWidth-1:0]   served_id;
    logic [FillWidth-1:0] fill_count;
  } outcome_t;

  // Shadow copy of the queue, head at slot 0
  logic [IdWidth-1:0]   queue_ids   [DEPTH];
  logic [PrioWidth-1:0] queue_prios [DEPTH];
  int unsigned          stored = 0;

  outcome_t due_results [$];
  int       mismatches = 0;
  int       backlog = 0;

  assign fail_count = mismatches;
  assign pending    = backlog;

  // Apply one request to the shadow queue and return the result it causes
  function automatic outcome_t predict_request(req_kind_t kind,
                                               logic [IdWidth-1:0] id,
                                               logic [PrioWidth-1:0] prio);
    outcome_t    outcome;
    int unsigned pos;
    outcome.served_id = '0;
    if (kind == REQ_INSERT) begin
      if (stored >= DEPTH) begin
        outcome.status = ST_FULL;
      end else begin
        // open a gap behind every entry of greater or equal priority
        pos = stored;
        while (pos > 0 && queue_prios[pos-1] < prio) begin
          queue_ids[pos]   = queue_ids[pos-1];
          queue_prios[pos] = queue_prios[pos-1];
          pos--;
        end
        queue_ids[pos]   = id;
        queue_prios[pos] = prio;
        stored++;
        outcome.status = ST_INSERTED;
      end
    end else begin
      if (stored == 0) begin
        outcome.status = ST_EMPTY;
      end else begin
        outcome.served_id = queue_ids[0];
        for (int k = 1; k < stored; k++) begin
          queue_ids[k-1]   = queue_ids[k];
          queue_prios[k-1] = queue_prios[k];
        end
        stored--;
        outcome.status = ST_REMOVED;
      end
    end
    outcome.fill_count = stored[FillWidth-1:0];
    return outcome;
  endfunction

  // Compare results first, then record the request taken at the same edge
  always @(posedge clk) begin
    outcome_t due;
    if (rst) begin
      stored = 0;
      due_results.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (due_results.size() == 0) begin
          $error("result item with no request outstanding: status %0d id %h fill %0d",
                 res.status, res.served_id, res.fill_count);
          mismatches++;
        end else begin
          due = due_results.pop_front();
          if (res.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, res.status);
            mismatches++;
          end
          if (res.served_id !== due.served_id) begin
            $error("served_id: expected %h, got %h", due.served_id, res.served_id);
            mismatches++;
          end
          if (res.fill_count !== due.fill_count) begin
            $error("fill_count: expected %0d, got %0d", due.fill_count, res.fill_count);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready)
        due_results.push_back(predict_request(req_kind_t'(req.req_type),
                                              req.item_id, req.priority_req));
    end
    backlog = due_results.size();
  end

endmodule

[bench/sorted_priority_queue_tb.sv]
// Top of the sorted priority queue bench: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on spq_pkg, both channel interfaces, the block and its checker.
module sorted_priority_queue_tb import spq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDepth     = DefaultDepth;
  localparam int RandItems  = 1250;
  localparam int LongHold   = 300;
  localparam int IdleLimit  = 5000;
  localparam int TailCycles = 20;

  logic clk;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;

  // set by the stimulus, read by the receiver
  bit   steady = 1'b0;
  bit   hold_wanted = 1'b0;
  bit   hold_done = 1'b0;

  spq_req_if req_ch ();
  spq_res_if res_ch ();

  sorted_priority_queue #(.DEPTH(QDepth)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  sorted_priority_queue_checker #(.DEPTH(QDepth)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Present one request item and wait until it is taken
  task automatic offer(req_kind_t kind, logic [15:0] id, logic [7:0] prio);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid        = 1'b1;
    req_ch.req_type     = kind;
    req_ch.item_id      = id;
    req_ch.priority_req = prio;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    int unsigned span;
    res_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_wanted && !hold_done) begin
        res_ch.ready = 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_done = 1'b1;
      end else if (steady) begin
        res_ch.ready = 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 9) < 6) begin
        res_ch.ready = 1'b1;
        span = $urandom_range(1, 8);
        repeat (span) @(negedge clk);
      end else begin
        res_ch.ready = 1'b0;
        span = idle_len();
        repeat (span) @(negedge clk);
      end
    end
  end

  // Watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    int          done;
    int unsigned burst;
    int unsigned insert_pct;
    int unsigned prio_span;
    int unsigned r;
    logic [7:0]  prio;
    req_kind_t   kind;

    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_INSERT;
    req_ch.item_id      = '0;
    req_ch.priority_req = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty remove, extreme fields, ties leave in arrival order
    offer(REQ_REMOVE, 16'hFFFF, 8'hFF);
    offer(REQ_INSERT, 16'hFFFF, 8'd255);
    offer(REQ_INSERT, 16'h0000, 8'd0);
    offer(REQ_INSERT, 16'h0001, 8'd128);
    offer(REQ_INSERT, 16'h0002, 8'd128);
    offer(REQ_INSERT, 16'h0003, 8'd255);
    repeat (5) offer(REQ_REMOVE, 16'h5A5A, 8'hA5);
    offer(REQ_REMOVE, 16'h0000, 8'h00);
    // fill to the brim, then one insert too many
    for (int k = 0; k < QDepth; k++)
      offer(REQ_INSERT, 16'h1000 + k[15:0], 8'($urandom_range(0, 7)));
    offer(REQ_INSERT, 16'hBEEF, 8'd200);

    // random bursts, each with its own insert/remove balance and priority spread
    done = 0;
    while (done < RandItems) begin
      r = $urandom_range(0, 2);
      insert_pct = (r == 0) ? 85 : (r == 1) ? 15 : 50;
      r = $urandom_range(0, 2);
      prio_span = (r == 0) ? 3 : (r == 1) ? 15 : 255;
      burst = $urandom_range(8, 60);
      repeat (burst) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        r = $urandom_range(0, 99);
        prio = (r < 5) ? 8'd255 : (r < 10) ? 8'd0 : 8'($urandom_range(0, prio_span));
        offer(kind, 16'($urandom), prio);
        done++;
        if (done == 300) steady = 1'b1;
        if (done == 400) steady = 1'b0;
        if (done == 600) hold_wanted = 1'b1;
        if (done == 900) drain();
      end
    end

    drain();
    repeat (TailCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
